[rtl/dtfg_pkg.sv]
package dtfg_pkg;

  localparam int unsigned MaxFracDigits = 4;
  localparam int unsigned WholeLimit    = 512;
  localparam int unsigned QFracBits     = 8;
  localparam int unsigned QCntW         = $clog2(QFracBits);
  localparam int unsigned FifoDepth     = 2;
  localparam int unsigned FifoPtrW      = $clog2(FifoDepth);
  localparam int unsigned FifoCntW      = $clog2(FifoDepth + 1);
  localparam int unsigned PaddrW        = 3;
  localparam int unsigned PdataW        = 32;

  localparam logic [PaddrW-3:0] RegIdxNoneValue = '0;

  typedef struct packed {
    logic        minus;
    logic [9:0]  whole;
    logic [13:0] frac;
    logic [2:0]  digits;
    logic        ovf;
  } parse_rec_t;

  function automatic logic [13:0] pow10(input logic [2:0] d);
    logic [13:0] r;
    unique case (d)
      3'd0:    r = 14'd1;
      3'd1:    r = 14'd10;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd1000;
      default: r = 14'd10000;
    endcase
    return r;
  endfunction

endpackage

[rtl/decibel_text_to_fixed_gain.sv]
// Decibel text to signed Q8.8 gain.
// Input: one character per cycle while full is low; full rises only while two finished strings wait.
// Per string end: the finished record is queued, loaded by the divide unit, taken
// through an 8-step restoring divide of the fraction by its power of ten, and then
// finished into the output slot once it is free. The divide unit takes one string at a time.
// Async active-low reset clears the parse, queue and output valid flag; none_value resets to -32768.
module decibel_text_to_fixed_gain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    character_i,
  input  logic                          present_i,
  input  logic                          last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [15:0]                   gain_o,
  output logic                          valid_res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtfg_pkg::PaddrW-1:0]   paddr,
  input  logic [dtfg_pkg::PdataW-1:0]   pwdata,
  output logic [dtfg_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  logic                 take;
  logic                 rec_push, rec_full, rec_pop, rec_empty;
  dtfg_pkg::parse_rec_t rec_in, rec_out;
  logic [15:0]          none_value_q;
  logic                 sel_none;

  assign take     = push && !full;
  assign full     = rec_full;
  assign pready   = 1'b1;
  assign sel_none = (paddr[dtfg_pkg::PaddrW-1:2] == dtfg_pkg::RegIdxNoneValue);
  assign prdata   = sel_none ?
                    {{(dtfg_pkg::PdataW - 16){none_value_q[15]}}, none_value_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      none_value_q <= 16'h8000;
    end else if (psel && penable && pwrite && pready && sel_none) begin
      none_value_q <= pwdata[15:0];
    end
  end

  dtfg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .character_i(character_i),
    .present_i  (present_i),
    .last_i     (last_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  dtfg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .wdata_i(rec_in),
    .full_o (rec_full),
    .pop_i  (rec_pop),
    .empty_o(rec_empty),
    .rdata_o(rec_out)
  );

  dtfg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (rec_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .none_value_i(none_value_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .gain_o      (gain_o),
    .valid_res_o (valid_res_o)
  );

endmodule

[rtl/dtfg_front.sv]
module dtfg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          character_i,
  input  logic                present_i,
  input  logic                last_i,
  output logic                rec_push_o,
  output dtfg_pkg::parse_rec_t rec_o
);

  localparam logic [1:0] PhSkip  = 2'd0;
  localparam logic [1:0] PhWhole = 2'd1;
  localparam logic [1:0] PhFrac  = 2'd2;
  localparam logic [1:0] PhDone  = 2'd3;

  logic [1:0]           phase_q, phase_d;
  dtfg_pkg::parse_rec_t cur_q, nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [12:0] whole_next;
  logic [13:0] frac_next;

  assign is_digit   = (character_i >= 8'h30) && (character_i <= 8'h39);
  assign digit      = 4'(character_i - 8'h30);
  assign whole_next = {cur_q.whole, 3'b000} + {2'b00, cur_q.whole, 1'b0} + 13'(digit);
  assign frac_next  = 14'({cur_q.frac, 3'b000} + {cur_q.frac, 1'b0}) + 14'(digit);

  always_comb begin
    nxt     = cur_q;
    phase_d = phase_q;
    if (present_i) begin
      unique case (phase_q)
        PhSkip: begin
          if (character_i == 8'h20 || character_i == 8'h2B) begin
            phase_d = PhSkip;
          end else if (character_i == 8'h2D) begin
            nxt.minus = 1'b1;
            phase_d   = PhWhole;
          end else if (is_digit) begin
            if (whole_next > 13'(dtfg_pkg::WholeLimit)) begin
              nxt.ovf = 1'b1;
              phase_d = PhDone;
            end else begin
              nxt.whole = whole_next[9:0];
              phase_d   = PhWhole;
            end
          end else if (character_i == 8'h2E) begin
            phase_d = PhFrac;
          end else begin
            phase_d = PhDone;
          end
        end
        PhWhole: begin
          if (is_digit) begin
            if (whole_next > 13'(dtfg_pkg::WholeLimit)) begin
              nxt.ovf = 1'b1;
              phase_d = PhDone;
            end else begin
              nxt.whole = whole_next[9:0];
            end
          end else if (character_i == 8'h2E) begin
            phase_d = PhFrac;
          end else begin
            phase_d = PhDone;
          end
        end
        PhFrac: begin
          if (is_digit && cur_q.digits < 3'(dtfg_pkg::MaxFracDigits)) begin
            nxt.frac   = frac_next;
            nxt.digits = cur_q.digits + 3'd1;
          end else begin
            phase_d = PhDone;
          end
        end
        default: phase_d = PhDone;
      endcase
    end
  end

  assign rec_o      = nxt;
  assign rec_push_o = take_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      cur_q   <= '0;
    end else if (take_i) begin
      if (last_i) begin
        phase_q <= PhSkip;
        cur_q   <= '0;
      end else begin
        phase_q <= phase_d;
        cur_q   <= nxt;
      end
    end
  end

endmodule

[rtl/dtfg_fifo.sv]
module dtfg_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dtfg_pkg::parse_rec_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output dtfg_pkg::parse_rec_t rdata_o
);

  dtfg_pkg::parse_rec_t                  mem_q [dtfg_pkg::FifoDepth];
  logic [dtfg_pkg::FifoPtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [dtfg_pkg::FifoCntW-1:0]         cnt_q;
  logic                                  do_push, do_pop;

  assign full_o  = (cnt_q == dtfg_pkg::FifoCntW'(dtfg_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/dtfg_back.sv]
module dtfg_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rec_empty_i,
  input  dtfg_pkg::parse_rec_t rec_i,
  output logic                 rec_pop_o,
  input  logic [15:0]          none_value_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [15:0]          gain_o,
  output logic                 valid_res_o
);

  localparam logic [1:0] BIdle = 2'd0;
  localparam logic [1:0] BDiv  = 2'd1;
  localparam logic [1:0] BFin  = 2'd2;

  logic [1:0]                     state_q;
  dtfg_pkg::parse_rec_t           rec_q;
  logic [14:0]                    rem_q;
  logic [13:0]                    div_q;
  logic [dtfg_pkg::QFracBits-1:0] quo_q;
  logic [dtfg_pkg::QCntW-1:0]     cnt_q;
  logic                           out_valid_q, out_valid_d;
  logic [15:0]                    gain_q;
  logic                           valid_q;

  logic [14:0] rem2;
  logic        ge;
  logic [17:0] mag;
  logic        ok;
  logic [15:0] gain_val;
  logic        slot_free;

  assign rem2      = {rem_q[13:0], 1'b0};
  assign ge        = rem2 >= {1'b0, div_q};
  assign mag       = {rec_q.whole, dtfg_pkg::QFracBits'(0)} + 18'(quo_q);
  assign ok        = !rec_q.ovf &&
                     (rec_q.minus ? (mag < 18'd32768) : (mag < 18'd32767));
  assign gain_val  = rec_q.minus ? 16'(-mag[15:0]) : mag[15:0];
  assign slot_free = !out_valid_q || pop_i;
  assign rec_pop_o = (state_q == BIdle) && !rec_empty_i;

  assign empty_o     = !out_valid_q;
  assign gain_o      = gain_q;
  assign valid_res_o = valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (state_q == BFin && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BIdle: begin
        rec_q <= rec_i;
        rem_q <= {1'b0, rec_i.frac};
        div_q <= dtfg_pkg::pow10(rec_i.digits);
        quo_q <= '0;
      end
      BDiv: begin
        rem_q <= ge ? (rem2 - {1'b0, div_q}) : rem2;
        quo_q <= {quo_q[dtfg_pkg::QFracBits-2:0], ge};
      end
      default: begin
      end
    endcase
    if (state_q == BFin && slot_free) begin
      gain_q  <= ok ? gain_val : none_value_i;
      valid_q <= ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        BIdle: begin
          cnt_q <= '0;
          if (!rec_empty_i) begin
            state_q <= BDiv;
          end
        end
        BDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == dtfg_pkg::QCntW'(dtfg_pkg::QFracBits - 1)) begin
            state_q <= BFin;
          end
        end
        BFin: begin
          if (slot_free) begin
            state_q <= BIdle;
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

endmodule

[tb/tb_decibel_text_to_fixed_gain.sv]
module tb_decibel_text_to_fixed_gain;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfg_pkg::*;

  localparam logic [7:0] ChSpace = " ";
  localparam logic [7:0] ChPlus  = "+";
  localparam logic [7:0] ChMinus = "-";
  localparam logic [7:0] ChDot   = ".";
  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChNine  = "9";

  localparam logic [PaddrW-1:0] AddrNoneValue = {RegIdxNoneValue, 2'b00};
  localparam logic [PaddrW-1:0] AddrUnmapped  = 3'd4;

  localparam int unsigned ItemsPerPhase = 390;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned DrainCycles   = 20;

  typedef enum logic [2:0] {
    PhSkipLead,
    PhWhole,
    PhFrac,
    PhStopped
  } parse_phase_e;

  typedef struct {
    logic [7:0] ch;
    logic       pres;
    logic       lst;
  } text_beat_t;

  typedef struct packed {
    logic [15:0] gain;
    logic        vld;
  } gain_rec_t;

  typedef struct {
    string       txt;
    int          hole;
    bit          typed;
    logic [15:0] gain;
    logic        vld;
  } directed_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [7:0]          character_i;
  logic                present_i;
  logic                last_i;
  logic                empty;
  logic                pop;
  logic [15:0]         gain_o;
  logic                valid_res_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  decibel_text_to_fixed_gain i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .character_i (character_i),
    .present_i   (present_i),
    .last_i      (last_i),
    .empty       (empty),
    .pop         (pop),
    .gain_o      (gain_o),
    .valid_res_o (valid_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // gain predictor state
  logic [15:0]   sentinel_gain;
  parse_phase_e  pm_phase;
  logic          pm_minus;
  logic [9:0]    pm_whole;
  logic [13:0]   pm_frac;
  logic [2:0]    pm_digits;
  logic          pm_ovf;

  gain_rec_t     gain_q[$];
  text_beat_t    beats[$];
  directed_row_t rows[8];

  int unsigned   err_cnt;
  int unsigned   beat_cnt;
  int unsigned   string_cnt;
  int unsigned   valid_cnt;
  int unsigned   invalid_cnt;
  bit            calm;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void clear_parse_model();
    pm_phase  = PhSkipLead;
    pm_minus  = 1'b0;
    pm_whole  = '0;
    pm_frac   = '0;
    pm_digits = '0;
    pm_ovf    = 1'b0;
  endfunction

  function automatic void model_whole_digit(input logic [7:0] c);
    int nxt;
    nxt = int'(pm_whole) * 10 + int'(c - ChZero);
    if (nxt > int'(WholeLimit)) begin
      pm_ovf   = 1'b1;
      pm_phase = PhStopped;
    end else begin
      pm_whole = nxt[9:0];
      pm_phase = PhWhole;
    end
  endfunction

  function automatic bit model_take(input text_beat_t b, output gain_rec_t r);
    bit is_dig;
    bit ok;
    int v;
    int scale;
    is_dig = (b.ch >= ChZero) && (b.ch <= ChNine);
    r = '0;
    if (b.pres) begin
      case (pm_phase)
        PhSkipLead: begin
          if (b.ch == ChSpace || b.ch == ChPlus) begin
          end else if (b.ch == ChMinus) begin
            pm_minus = 1'b1;
            pm_phase = PhWhole;
          end else if (is_dig) begin
            model_whole_digit(b.ch);
          end else if (b.ch == ChDot) begin
            pm_phase = PhFrac;
          end else begin
            pm_phase = PhStopped;
          end
        end
        PhWhole: begin
          if (is_dig) begin
            model_whole_digit(b.ch);
          end else if (b.ch == ChDot) begin
            pm_phase = PhFrac;
          end else begin
            pm_phase = PhStopped;
          end
        end
        PhFrac: begin
          if (is_dig && pm_digits < MaxFracDigits) begin
            pm_frac   = 14'(pm_frac * 10 + (b.ch - ChZero));
            pm_digits = pm_digits + 3'd1;
          end else begin
            pm_phase = PhStopped;
          end
        end
        default: pm_phase = PhStopped;
      endcase
    end
    if (!b.lst) return 1'b0;
    ok = !pm_ovf;
    v = 0;
    if (ok) begin
      case (pm_digits)
        3'd0:    scale = 1;
        3'd1:    scale = 10;
        3'd2:    scale = 100;
        3'd3:    scale = 1000;
        default: scale = 10000;
      endcase
      v = int'(pm_whole) * 256 + (int'(pm_frac) * 256) / scale;
      if (pm_minus) v = -v;
      if (v <= -32768 || v >= 32767) ok = 1'b0;
    end
    r.gain = ok ? v[15:0] : sentinel_gain;
    r.vld  = ok;
    clear_parse_model();
    return 1'b1;
  endfunction

  task automatic send_beats(input bit typed, input gain_rec_t typed_rec);
    gain_rec_t r;
    foreach (beats[i]) begin
      while (!calm && $urandom_range(99) < 25) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
      push        <= 1'b1;
      character_i <= beats[i].ch;
      present_i   <= beats[i].pres;
      last_i      <= beats[i].lst;
      do @(posedge clk_i); while (full);
      beat_cnt++;
      if (model_take(beats[i], r)) begin
        gain_q.push_back(typed ? typed_rec : r);
        string_cnt++;
      end
    end
  endtask

  function automatic void add_beat(input logic [7:0] c);
    beats.push_back('{ch: c, pres: 1'b1, lst: 1'b0});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_beat(s[i]);
  endfunction

  function automatic void build_random_string();
    int mode;
    int n;
    text_beat_t tmp[$];
    int unsigned boundary[7] = '{127, 128, 255, 511, 512, 513, 999};
    beats.delete();
    mode = $urandom_range(99);
    if (mode < 8) begin
      repeat ($urandom_range(6, 1)) add_beat(8'($urandom_range(255)));
    end else if (mode >= 11) begin
      repeat ($urandom_range(2)) add_beat($urandom_range(1) ? ChSpace : ChPlus);
      if ($urandom_range(99) < 40) add_beat(ChMinus);
      case ($urandom_range(4))
        0: ;
        1: add_beat(8'(ChZero + $urandom_range(9)));
        2: add_text($sformatf("%0d", $urandom_range(600)));
        3: add_text($sformatf("%0d", boundary[$urandom_range(6)]));
        default: add_text($sformatf("00%0d", $urandom_range(99)));
      endcase
      if ($urandom_range(99) < 65) begin
        add_beat(ChDot);
        repeat ($urandom_range(5)) add_beat(8'(ChZero + $urandom_range(9)));
      end
      n = $urandom_range(99);
      if (n < 30) add_text(" dB");
      else if (n < 45) add_beat(8'($urandom_range(255)));
    end
    foreach (beats[i]) begin
      if ($urandom_range(99) < 8)
        tmp.push_back('{ch: 8'($urandom_range(255)), pres: 1'b0, lst: 1'b0});
      tmp.push_back(beats[i]);
    end
    if (tmp.size() == 0 || $urandom_range(99) < 10)
      tmp.push_back('{ch: 8'($urandom_range(255)), pres: 1'b0, lst: 1'b0});
    tmp[tmp.size()-1].lst = 1'b1;
    beats = tmp;
  endfunction

  task automatic apb_write(input logic [PaddrW-1:0] a, input logic [PdataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (a[PaddrW-1:2] == RegIdxNoneValue) sentinel_gain = d[15:0];
  endtask

  task automatic apb_check_sentinel();
    logic [PdataW-1:0] d;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrNoneValue;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (d[15:0] !== sentinel_gain) begin
      $error("none_value: expected %h, got %h", sentinel_gain, d[15:0]);
      err_cnt++;
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (gain_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // result checker
  initial begin
    gain_rec_t exp_rec;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (gain_q.size() == 0) begin
          $error("unexpected transaction: gain %h valid_res %b", gain_o, valid_res_o);
          err_cnt++;
        end else begin
          exp_rec = gain_q.pop_front();
          if (gain_o !== exp_rec.gain) begin
            $error("gain: expected %h, got %h", exp_rec.gain, gain_o);
            err_cnt++;
          end
          if (valid_res_o !== exp_rec.vld) begin
            $error("valid_res: expected %b, got %b", exp_rec.vld, valid_res_o);
            err_cnt++;
          end
          if (exp_rec.vld) valid_cnt++;
          else invalid_cnt++;
        end
      end
      pop <= calm || ($urandom_range(99) >= 25);
    end
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [15:0] setting;
    int unsigned goal;
    push        <= 1'b0;
    character_i <= '0;
    present_i   <= 1'b0;
    last_i      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    rst_ni      = 1'b0;
    err_cnt     = 0;
    beat_cnt    = 0;
    string_cnt  = 0;
    valid_cnt   = 0;
    invalid_cnt = 0;
    calm        = 1'b0;
    sentinel_gain = 16'h8000;
    clear_parse_model();

    rows[0] = '{txt: "",       hole: -1, typed: 1, gain: 16'h0000, vld: 1'b1};
    rows[1] = '{txt: "-7.25",  hole: 2,  typed: 0, gain: 16'h0000, vld: 1'b0};
    rows[2] = '{txt: "513",    hole: -1, typed: 1, gain: 16'h8000, vld: 1'b0};
    rows[3] = '{txt: "-128",   hole: -1, typed: 1, gain: 16'h8000, vld: 1'b0};
    rows[4] = '{txt: ".",      hole: -1, typed: 1, gain: 16'h0000, vld: 1'b1};
    rows[5] = '{txt: "+5.",    hole: -1, typed: 1, gain: 16'h0500, vld: 1'b1};
    rows[6] = '{txt: "x",      hole: -1, typed: 1, gain: 16'h0000, vld: 1'b1};
    rows[7] = '{txt: ".12345", hole: -1, typed: 0, gain: 16'h0000, vld: 1'b0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_check_sentinel();
    foreach (rows[k]) begin
      beats.delete();
      add_text(rows[k].txt);
      if (rows[k].hole >= 0)
        beats.insert(rows[k].hole, '{ch: 8'($urandom_range(255)), pres: 1'b0, lst: 1'b0});
      if (beats.size() == 0)
        beats.push_back('{ch: 8'($urandom_range(255)), pres: 1'b0, lst: 1'b0});
      beats[beats.size()-1].lst = 1'b1;
      send_beats(rows[k].typed, '{gain: rows[k].gain, vld: rows[k].vld});
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph)
        0:       setting = 16'h7FFF;
        1:       setting = 16'h0000;
        2:       setting = 16'($urandom_range(16'hFFFF));
        3:       setting = 16'hFFFF;
        default: setting = 16'h8000;
      endcase
      apb_write(AddrNoneValue, {{16{setting[15]}}, setting});
      if (ph == 1) apb_write(AddrUnmapped, 32'($urandom));
      apb_check_sentinel();
      calm = (ph == 2);
      goal = beat_cnt + ItemsPerPhase;
      while (beat_cnt < goal) begin
        build_random_string();
        send_beats(1'b0, '0);
      end
    end
    calm = 1'b0;
    drain_results();

    $display("covered %0d strings in %0d characters: %0d valid gains, %0d sentinels",
             string_cnt, beat_cnt, valid_cnt, invalid_cnt);
    $display("sentinel settings: reset, max, zero, random, minus one, min");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dtfg_pkg.sv
rtl/dtfg_front.sv
rtl/dtfg_fifo.sv
rtl/dtfg_back.sv
rtl/decibel_text_to_fixed_gain.sv
tb/tb_decibel_text_to_fixed_gain.sv
